// ----- rtl/core/compressed_riscv_execute_unit_macros.svh -----
// assertion macros used by the execute unit checker
`ifndef COMPRESSED_RISCV_EXECUTE_UNIT_MACROS_SVH
`define COMPRESSED_RISCV_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define CRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define CRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cre_pkg.sv -----
// shared types, constants and status codes of the compressed execute unit
package cre_pkg;

  localparam int XLEN     = 64;
  localparam int NUM_REGS = 32;
  localparam int RIDX_W   = $clog2(NUM_REGS);
  localparam int HALF     = XLEN / 2;
  localparam bit IS64     = (XLEN >= 64);

  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_RESP = 1'b1;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_STORE   = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_BREAK   = 3'd4;
  localparam logic [2:0] ST_LOADED  = 3'd5;

  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;

  localparam logic [1:0] SZ_B = 2'd0;
  localparam logic [1:0] SZ_H = 2'd1;
  localparam logic [1:0] SZ_W = 2'd2;
  localparam logic [1:0] SZ_D = 2'd3;

  typedef struct packed {
    logic [2:0]        status;
    logic [XLEN-1:0]   next_pc;
    logic [XLEN-1:0]   addr;
    logic [1:0]        size;
    logic [XLEN-1:0]   sdata;
    logic              wbv;
    logic [RIDX_W-1:0] wbr;
    logic [XLEN-1:0]   wbval;
  } res_t;

  typedef struct packed {
    logic              pending;
    logic [RIDX_W-1:0] dest;
    logic [1:0]        width;
    logic              sign;
  } ld_t;

endpackage

// ----- rtl/core/cre_exec.sv -----
// decode and execute of one compressed instruction or load response
module cre_exec
  import cre_pkg::*;
(
  input  logic            cmd,
  input  logic [15:0]     instr,
  input  logic [XLEN-1:0] pc,
  input  logic [XLEN-1:0] ldata,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic [XLEN-1:0] mul_res,
  input  ld_t             ld,
  output res_t            res,
  output ld_t             ld_nxt,
  output logic            is_mul
);

  logic [2:0]        f3;
  logic [1:0]        f2;
  logic [RIDX_W-1:0] rd, rs2, rdp;
  logic [5:0]        sh;
  logic [XLEN-1:0]   imm6, joff, boff, pc2, lv;
  logic [6:0]        offw;
  logic [7:0]        offd;
  logic [9:0]        u4spn, u16sp;
  logic              sh_bad;
  logic              ok, wreq;
  logic [RIDX_W-1:0] widx;
  logic [XLEN-1:0]   wval;

  assign f3    = instr[15:13];
  assign f2    = instr[11:10];
  assign rd    = instr[11:7];
  assign rs2   = instr[6:2];
  assign rdp   = {2'b01, instr[4:2]};
  assign sh    = {instr[12], instr[6:2]};
  assign sh_bad = ({1'b0, sh} >= 7'(XLEN));
  assign imm6  = XLEN'($signed({instr[12], instr[6:2]}));
  assign joff  = XLEN'($signed({instr[12], instr[8], instr[10:9], instr[6], instr[7],
                                instr[2], instr[11], instr[5:3], 1'b0}));
  assign boff  = XLEN'($signed({instr[12], instr[6:5], instr[2], instr[11:10],
                                instr[4:3], 1'b0}));
  assign pc2   = pc + XLEN'(2);
  assign offw  = {instr[5], instr[12:10], instr[6], 2'b00};
  assign offd  = {instr[6:5], instr[12:10], 3'b000};
  assign u4spn = {instr[10:7], instr[12:11], instr[5], instr[6], 2'b00};
  assign u16sp = {instr[12], instr[4:3], instr[5], instr[2], instr[6], 4'b0000};

  // load response value
  always_comb begin
    case (ld.width)
      SZ_B:    lv = ld.sign ? XLEN'($signed(ldata[7:0]))  : XLEN'(ldata[7:0]);
      SZ_H:    lv = ld.sign ? XLEN'($signed(ldata[15:0])) : XLEN'(ldata[15:0]);
      SZ_W:    lv = ld.sign ? XLEN'($signed(ldata[31:0])) : XLEN'(ldata[31:0]);
      default: lv = ldata;
    endcase
  end

  always_comb begin
    res         = '0;
    res.status  = ST_DONE;
    res.next_pc = pc2;
    ld_nxt      = ld;
    is_mul      = 1'b0;
    ok          = 1'b1;
    wreq        = 1'b0;
    widx        = '0;
    wval        = '0;
    if (cmd == CMD_RESP) begin
      res.next_pc = '0;
      if (ld.pending) begin
        wreq           = 1'b1;
        widx           = ld.dest;
        wval           = lv;
        res.status     = ST_LOADED;
        ld_nxt.pending = 1'b0;
      end
    end else begin
      case (instr[1:0])
        QUAD0: begin
          case (f3)
            3'd0: begin
              if (u4spn == '0) ok = 1'b0;
              else begin
                wreq = 1'b1; widx = rdp; wval = a + XLEN'(u4spn);
              end
            end
            3'd2: begin
              res.status = ST_LOAD; res.addr = a + XLEN'(offw); res.size = SZ_W;
              ld_nxt = '{pending: 1'b1, dest: rdp, width: SZ_W, sign: 1'b1};
            end
            3'd3: begin
              if (!IS64) ok = 1'b0;
              else begin
                res.status = ST_LOAD; res.addr = a + XLEN'(offd); res.size = SZ_D;
                ld_nxt = '{pending: 1'b1, dest: rdp, width: SZ_D, sign: 1'b0};
              end
            end
            3'd4: begin
              case (instr[12:10])
                3'd0: begin
                  res.status = ST_LOAD; res.size = SZ_B;
                  res.addr = a + XLEN'({instr[5], instr[6]});
                  ld_nxt = '{pending: 1'b1, dest: rdp, width: SZ_B, sign: 1'b0};
                end
                3'd1: begin
                  res.status = ST_LOAD; res.size = SZ_H;
                  res.addr = a + XLEN'({instr[5], 1'b0});
                  ld_nxt = '{pending: 1'b1, dest: rdp, width: SZ_H, sign: instr[6]};
                end
                3'd2: begin
                  res.status = ST_STORE; res.size = SZ_B; res.sdata = b;
                  res.addr = a + XLEN'({instr[5], instr[6]});
                end
                3'd3: begin
                  if (instr[6]) ok = 1'b0;
                  else begin
                    res.status = ST_STORE; res.size = SZ_H; res.sdata = b;
                    res.addr = a + XLEN'({instr[5], 1'b0});
                  end
                end
                default: ok = 1'b0;
              endcase
            end
            3'd6: begin
              res.status = ST_STORE; res.size = SZ_W; res.sdata = b;
              res.addr = a + XLEN'(offw);
            end
            3'd7: begin
              if (!IS64) ok = 1'b0;
              else begin
                res.status = ST_STORE; res.size = SZ_D; res.sdata = b;
                res.addr = a + XLEN'(offd);
              end
            end
            default: ok = 1'b0;
          endcase
        end
        QUAD1: begin
          case (f3)
            3'd0: begin
              wreq = 1'b1; widx = rd; wval = a + imm6;
            end
            3'd1: begin
              if (IS64) begin
                if (rd == '0) ok = 1'b0;
                else begin
                  wval = a + imm6;
                  wval = XLEN'($signed(wval[31:0]));
                  wreq = 1'b1; widx = rd;
                end
              end else begin
                wreq = 1'b1; widx = RIDX_W'(1); wval = pc2;
                res.next_pc = pc + joff;
              end
            end
            3'd2: begin
              wreq = 1'b1; widx = rd; wval = imm6;
            end
            3'd3: begin
              if (rd == RIDX_W'(2)) begin
                if (u16sp == '0) ok = 1'b0;
                else begin
                  wreq = 1'b1; widx = rd; wval = a + XLEN'($signed(u16sp));
                end
              end else if ({instr[12], instr[6:2]} == 6'd0) begin
                ok = 1'b0;
              end else begin
                wreq = 1'b1; widx = rd;
                wval = XLEN'($signed({instr[12], instr[6:2], 12'd0}));
              end
            end
            3'd4: begin
              widx = rdp;
              widx[2:0] = instr[9:7];
              case (f2)
                2'd0, 2'd1: begin
                  if (sh_bad) ok = 1'b0;
                  else begin
                    wreq = 1'b1;
                    wval = (f2 == 2'd0) ? (a >> sh) : XLEN'($signed(a) >>> sh);
                  end
                end
                2'd2: begin
                  wreq = 1'b1; wval = a & XLEN'($signed(sh));
                end
                default: begin
                  wreq = 1'b1;
                  case ({instr[12], instr[6:5]})
                    3'd0: wval = a - b;
                    3'd1: wval = a ^ b;
                    3'd2: wval = a | b;
                    3'd3: wval = a & b;
                    3'd4: begin
                      if (!IS64) ok = 1'b0;
                      wval = a - b;
                      wval = XLEN'($signed(wval[31:0]));
                    end
                    3'd5: begin
                      if (!IS64) ok = 1'b0;
                      wval = a + b;
                      wval = XLEN'($signed(wval[31:0]));
                    end
                    3'd6: begin
                      is_mul = 1'b1; wval = mul_res;
                    end
                    default: begin
                      case (instr[4:2])
                        3'd0: wval = XLEN'(a[7:0]);
                        3'd1: wval = XLEN'($signed(a[7:0]));
                        3'd2: wval = XLEN'(a[15:0]);
                        3'd3: wval = XLEN'($signed(a[15:0]));
                        3'd4: begin
                          if (!IS64) ok = 1'b0;
                          wval = XLEN'(a[31:0]);
                        end
                        3'd5: wval = ~a;
                        default: ok = 1'b0;
                      endcase
                    end
                  endcase
                end
              endcase
            end
            3'd5: res.next_pc = pc + joff;
            default: begin
              if ((f3 == 3'd6) == (a == '0)) res.next_pc = pc + boff;
            end
          endcase
        end
        QUAD2: begin
          case (f3)
            3'd0: begin
              if (sh_bad) ok = 1'b0;
              else begin
                wreq = 1'b1; widx = rd; wval = a << sh;
              end
            end
            3'd2: begin
              if (rd == '0) ok = 1'b0;
              else begin
                res.status = ST_LOAD; res.size = SZ_W;
                res.addr = a + XLEN'({instr[3:2], instr[12], instr[6:4], 2'b00});
                ld_nxt = '{pending: 1'b1, dest: rd, width: SZ_W, sign: 1'b1};
              end
            end
            3'd3: begin
              if (!IS64 || rd == '0) ok = 1'b0;
              else begin
                res.status = ST_LOAD; res.size = SZ_D;
                res.addr = a + XLEN'({instr[4:2], instr[12], instr[6:5], 3'b000});
                ld_nxt = '{pending: 1'b1, dest: rd, width: SZ_D, sign: 1'b0};
              end
            end
            3'd4: begin
              if (!instr[12]) begin
                if (rs2 != '0) begin
                  wreq = 1'b1; widx = rd; wval = b;
                end else if (rd == '0) begin
                  ok = 1'b0;
                end else begin
                  res.next_pc = {a[XLEN-1:1], 1'b0};
                end
              end else begin
                if (rs2 != '0) begin
                  wreq = 1'b1; widx = rd; wval = a + b;
                end else if (rd == '0) begin
                  res.status = ST_BREAK; res.next_pc = pc;
                end else begin
                  // target comes from the old rs1 value, link written after
                  res.next_pc = {a[XLEN-1:1], 1'b0};
                  wreq = 1'b1; widx = RIDX_W'(1); wval = pc2;
                end
              end
            end
            3'd6: begin
              res.status = ST_STORE; res.size = SZ_W; res.sdata = b;
              res.addr = a + XLEN'({instr[8:7], instr[12:9], 2'b00});
            end
            3'd7: begin
              if (!IS64) ok = 1'b0;
              else begin
                res.status = ST_STORE; res.size = SZ_D; res.sdata = b;
                res.addr = a + XLEN'({instr[9:7], instr[12:10], 3'b000});
              end
            end
            default: ok = 1'b0;
          endcase
        end
        default: ok = 1'b0;
      endcase
    end
    res.wbv   = wreq && (widx != '0);
    res.wbr   = res.wbv ? widx : '0;
    res.wbval = res.wbv ? wval : '0;
    if (!ok) begin
      res         = '0;
      res.status  = ST_ILLEGAL;
      res.next_pc = pc;
      ld_nxt      = ld;
      is_mul      = 1'b0;
    end
  end

endmodule

// ----- rtl/core/compressed_riscv_execute_unit.sv -----
// top level: register file memory, execute stage and result register
//
// usage
//   input channel (in_valid/in_stall) carries either a compressed instruction
//   (in_cmd 0) or the data for the pending load (in_cmd 1)
//   result channel (out_valid/out_stall) gives one result per input transfer,
//   in order
//   an input passes the execute stage registers and then the result register;
//   a MUL also waits in the execute stage for the split 32x32 partial products
//   throughput: one item per cycle unless the receiver stalls or a MUL waits
//   the integer registers sit in a synchronous memory with two read ports,
//   read at the input transfer; the write of the item leaving the execute
//   stage in that same cycle is forwarded
//   a load reports its address and size; its later response transfer
//   writes the extended data back
//   reset clears the per-register valid bits (registers then read zero),
//   the pending load and both stage valids; no clearing pass is needed
//   when the receiver stalls, the result register holds and the execute
//   stage backs up; in_stall rises only while the execute stage is full
//   and cannot move
module compressed_riscv_execute_unit
  import cre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_instr,
  input  logic [63:0] in_pc,
  input  logic [63:0] in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_next_pc,
  output logic [63:0] out_mem_address,
  output logic [1:0]  out_mem_size,
  output logic [63:0] out_store_data,
  output logic        out_wb_valid,
  output logic [4:0]  out_wb_reg,
  output logic [63:0] out_wb_value
);

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   val;
  } fwd_t;

  // register file storage and per-entry valid bits
  logic [XLEN-1:0]     rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  // execute stage
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [15:0]       s1_instr_r;
  logic [XLEN-1:0]   s1_pc_r, s1_ldata_r;
  logic [RIDX_W-1:0] ra_idx_r, rb_idx_r;
  logic [XLEN-1:0]   ra_q_r, rb_q_r;
  logic              ra_vld_r, rb_vld_r;
  fwd_t              fwd_r;
  ld_t               ld_r;
  logic              mul_ph_r;
  logic [XLEN-1:0]   pp_lo_r;
  logic [HALF-1:0]   pp_x1_r, pp_x2_r;

  // result register
  logic              out_valid_r;
  res_t              res_r;

  logic              acc, adv, s1_done;
  logic [RIDX_W-1:0] ra_idx, rb_idx;
  logic [XLEN-1:0]   opa, opb, mul_res;
  res_t              res;
  ld_t               ld_nxt;
  logic              is_mul;
  logic [2:0]        in_f3;

  // read port selection from the incoming instruction word
  assign in_f3 = in_instr[15:13];
  always_comb begin
    ra_idx = in_instr[11:7];
    rb_idx = {2'b01, in_instr[4:2]};
    case (in_instr[1:0])
      QUAD0: begin
        ra_idx = (in_f3 == 3'd0) ? RIDX_W'(2) : {2'b01, in_instr[9:7]};
      end
      QUAD1: begin
        if (in_f3[2]) ra_idx = {2'b01, in_instr[9:7]};
      end
      QUAD2: begin
        rb_idx = in_instr[6:2];
        if (in_f3 == 3'd2 || in_f3 == 3'd3 || in_f3 == 3'd6 || in_f3 == 3'd7) begin
          ra_idx = RIDX_W'(2);
        end
      end
      default: ;
    endcase
  end

  // operands: x0 reads zero, the write of the accept cycle is forwarded
  always_comb begin
    if (ra_idx_r == '0)                      opa = '0;
    else if (fwd_r.en && fwd_r.idx == ra_idx_r) opa = fwd_r.val;
    else                                     opa = ra_vld_r ? ra_q_r : '0;
    if (rb_idx_r == '0)                      opb = '0;
    else if (fwd_r.en && fwd_r.idx == rb_idx_r) opb = fwd_r.val;
    else                                     opb = rb_vld_r ? rb_q_r : '0;
  end

  // low half of the product from registered partial products
  assign mul_res = pp_lo_r + {pp_x1_r + pp_x2_r, {HALF{1'b0}}};

  cre_exec u_exec (
    .cmd     (s1_cmd_r),
    .instr   (s1_instr_r),
    .pc      (s1_pc_r),
    .ldata   (s1_ldata_r),
    .a       (opa),
    .b       (opb),
    .mul_res (mul_res),
    .ld      (ld_r),
    .res     (res),
    .ld_nxt  (ld_nxt),
    .is_mul  (is_mul)
  );

  // handshake
  assign s1_done  = !is_mul || mul_ph_r;
  assign adv      = s1_valid_r && s1_done && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign acc      = in_valid && !in_stall;

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (adv && res.wbv) rf_mem[res.wbr] <= res.wbval;
    if (acc) begin
      ra_q_r <= rf_mem[ra_idx];
      rb_q_r <= rf_mem[rb_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mul_ph_r    <= 1'b0;
      ld_r        <= '0;
      fwd_r       <= '0;
      ra_vld_r    <= 1'b0;
      rb_vld_r    <= 1'b0;
    end else begin
      if (adv && res.wbv) vld_r[res.wbr] <= 1'b1;
      if (acc) begin
        s1_valid_r <= 1'b1;
        ra_vld_r   <= vld_r[ra_idx];
        rb_vld_r   <= vld_r[rb_idx];
        fwd_r.en   <= adv && res.wbv;
        fwd_r.idx  <= res.wbr;
        fwd_r.val  <= res.wbval;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        ld_r        <= ld_nxt;
        mul_ph_r    <= 1'b0;
      end else begin
        if (!out_stall) out_valid_r <= 1'b0;
        if (s1_valid_r && is_mul) mul_ph_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r   <= in_cmd;
      s1_instr_r <= in_instr;
      s1_pc_r    <= in_pc[XLEN-1:0];
      s1_ldata_r <= in_load_data[XLEN-1:0];
      ra_idx_r   <= ra_idx;
      rb_idx_r   <= rb_idx;
    end
    if (!mul_ph_r) begin
      pp_lo_r <= opa[HALF-1:0] * opb[HALF-1:0];
      pp_x1_r <= HALF'(opa[HALF-1:0] * opb[XLEN-1:HALF]);
      pp_x2_r <= HALF'(opa[XLEN-1:HALF] * opb[HALF-1:0]);
    end
    if (adv) res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_next_pc     = 64'(res_r.next_pc);
  assign out_mem_address = 64'(res_r.addr);
  assign out_mem_size    = res_r.size;
  assign out_store_data  = 64'(res_r.sdata);
  assign out_wb_valid    = res_r.wbv;
  assign out_wb_reg      = res_r.wbr;
  assign out_wb_value    = 64'(res_r.wbval);

endmodule

// ----- rtl/core/cre_checker.sv -----
// port-level checker for the execute unit and its bind
`include "compressed_riscv_execute_unit_macros.svh"

module cre_checker
  import cre_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [63:0] out_next_pc,
  input logic [1:0]  out_mem_size,
  input logic        out_wb_valid,
  input logic [4:0]  out_wb_reg
);

  `CRE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_next_pc), "stalled result changed")
  `CRE_ASSERT_NOW(a_no_x0, clk, rst_n, out_valid && out_wb_valid, out_wb_reg != 5'd0, "write-back to x0")
  `CRE_ASSERT_NOW(a_illegal, clk, rst_n, out_valid && (out_status == ST_ILLEGAL || out_status == ST_BREAK), !out_wb_valid && out_mem_size == 2'd0, "trap with side effect")
  `CRE_ASSERT_NOW(a_store, clk, rst_n, out_valid && out_status == ST_STORE, !out_wb_valid, "store wrote a register")

endmodule

bind compressed_riscv_execute_unit cre_checker u_cre_checker (.*);

// ----- test/tb_compressed_riscv_execute_unit.sv -----
// testbench of the compressed execute unit: predicted results against the block
module tb_compressed_riscv_execute_unit;
  import cre_pkg::*;

  // predictor of the execute unit plus store of predicted results
  class rvc_scoreboard;
    logic [63:0] regs [32];
    bit          ld_pend;
    logic [4:0]  ld_dest;
    logic [1:0]  ld_width;
    bit          ld_sign;
    res_t        pending_q [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      ld_pend = 0;
      ld_dest = '0;
      ld_width = SZ_B;
      ld_sign = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] rd_reg(logic [4:0] idx);
      return (idx == 0) ? 64'd0 : regs[idx];
    endfunction

    function void wr_reg(ref res_t r, input logic [4:0] idx, input logic [63:0] v);
      if (idx == 0) return;
      regs[idx] = v;
      r.wbv = 1'b1;
      r.wbr = idx;
      r.wbval = v;
    endfunction

    function logic [63:0] sext(logic [63:0] v, int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      if (bits < 64) v = v & ((64'd1 << bits) - 1);
      return (v ^ m) - m;
    endfunction

    function void req_load(ref res_t r, input logic [63:0] a, input logic [1:0] w,
                           input bit s, input logic [4:0] d);
      r.status = ST_LOAD;
      r.addr = a;
      r.size = w;
      ld_pend = 1;
      ld_dest = d;
      ld_width = w;
      ld_sign = s;
    endfunction

    function void give_store(ref res_t r, input logic [63:0] a, input logic [1:0] w,
                             input logic [63:0] d);
      r.status = ST_STORE;
      r.addr = a;
      r.size = w;
      r.sdata = d;
    endfunction

    function bit run_q0(ref res_t r, input logic [15:0] c);
      logic [4:0]  rs1, rd;
      logic [63:0] base, offw, offd, u;
      rs1 = {2'b01, c[9:7]};
      rd = {2'b01, c[4:2]};
      base = rd_reg(rs1);
      offw = {57'd0, c[5], c[12:10], c[6], 2'b00};
      offd = {56'd0, c[6:5], c[12:10], 3'b000};
      case (c[15:13])
        3'd0: begin
          u = {54'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
          if (u == 0) return 0;
          wr_reg(r, rd, rd_reg(5'd2) + u);
        end
        3'd2: req_load(r, base + offw, SZ_W, 1, rd);
        3'd3: req_load(r, base + offd, SZ_D, 0, rd);
        3'd4: begin
          case (c[12:10])
            3'd0: req_load(r, base + {62'd0, c[5], c[6]}, SZ_B, 0, rd);
            3'd1: req_load(r, base + {62'd0, c[5], 1'b0}, SZ_H, c[6], rd);
            3'd2: give_store(r, base + {62'd0, c[5], c[6]}, SZ_B, rd_reg(rd));
            3'd3: begin
              if (c[6]) return 0;
              give_store(r, base + {62'd0, c[5], 1'b0}, SZ_H, rd_reg(rd));
            end
            default: return 0;
          endcase
        end
        3'd6: give_store(r, base + offw, SZ_W, rd_reg(rd));
        3'd7: give_store(r, base + offd, SZ_D, rd_reg(rd));
        default: return 0;
      endcase
      return 1;
    endfunction

    function bit run_alu(ref res_t r, input logic [15:0] c);
      logic [4:0]  d, s;
      logic [5:0]  sh;
      logic [63:0] a, b, v;
      d = {2'b01, c[9:7]};
      s = {2'b01, c[4:2]};
      sh = {c[12], c[6:2]};
      a = rd_reg(d);
      b = rd_reg(s);
      case (c[11:10])
        2'd0: begin wr_reg(r, d, a >> sh); return 1; end
        2'd1: begin wr_reg(r, d, $unsigned($signed(a) >>> sh)); return 1; end
        2'd2: begin wr_reg(r, d, a & sext({58'd0, sh}, 6)); return 1; end
        default: ;
      endcase
      case ({c[12], c[6:5]})
        3'd0: v = a - b;
        3'd1: v = a ^ b;
        3'd2: v = a | b;
        3'd3: v = a & b;
        3'd4: v = sext(a - b, 32);
        3'd5: v = sext(a + b, 32);
        3'd6: v = a * b;
        default: begin
          case (c[4:2])
            3'd0: v = a & 64'hFF;
            3'd1: v = sext(a, 8);
            3'd2: v = a & 64'hFFFF;
            3'd3: v = sext(a, 16);
            3'd4: v = a & 64'hFFFF_FFFF;
            3'd5: v = ~a;
            default: return 0;
          endcase
        end
      endcase
      wr_reg(r, d, v);
      return 1;
    endfunction

    function bit run_q1(ref res_t r, input logic [15:0] c, input logic [63:0] pc);
      logic [4:0]  rd;
      logic [63:0] imm6, joff, boff, u, x;
      rd = c[11:7];
      imm6 = sext({58'd0, c[12], c[6:2]}, 6);
      joff = sext({52'd0, c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0}, 12);
      boff = sext({55'd0, c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0}, 9);
      case (c[15:13])
        3'd0: wr_reg(r, rd, rd_reg(rd) + imm6);
        3'd1: begin
          if (rd == 0) return 0;
          wr_reg(r, rd, sext(rd_reg(rd) + imm6, 32));
        end
        3'd2: wr_reg(r, rd, imm6);
        3'd3: begin
          if (rd == 2) begin
            u = {54'd0, c[12], c[4:3], c[5], c[2], c[6], 4'd0};
            if (u == 0) return 0;
            wr_reg(r, 5'd2, rd_reg(5'd2) + sext(u, 10));
          end else begin
            u = {46'd0, c[12], c[6:2], 12'd0};
            if (u == 0) return 0;
            wr_reg(r, rd, sext(u, 18));
          end
        end
        3'd4: return run_alu(r, c);
        3'd5: r.next_pc = pc + joff;
        default: begin
          x = rd_reg({2'b01, c[9:7]});
          if ((c[15:13] == 3'd6) == (x == 0)) r.next_pc = pc + boff;
        end
      endcase
      return 1;
    endfunction

    function bit run_q2(ref res_t r, input logic [15:0] c, input logic [63:0] pc);
      logic [4:0]  rd, rs2;
      logic [63:0] t;
      rd = c[11:7];
      rs2 = c[6:2];
      case (c[15:13])
        3'd0: wr_reg(r, rd, rd_reg(rd) << {c[12], c[6:2]});
        3'd2: begin
          if (rd == 0) return 0;
          req_load(r, rd_reg(5'd2) + {56'd0, c[3:2], c[12], c[6:4], 2'b00}, SZ_W, 1, rd);
        end
        3'd3: begin
          if (rd == 0) return 0;
          req_load(r, rd_reg(5'd2) + {55'd0, c[4:2], c[12], c[6:5], 3'b000}, SZ_D, 0, rd);
        end
        3'd4: begin
          if (!c[12]) begin
            if (rs2 != 0) wr_reg(r, rd, rd_reg(rs2));
            else if (rd == 0) return 0;
            else r.next_pc = rd_reg(rd) & ~64'd1;
          end else if (rs2 != 0) begin
            wr_reg(r, rd, rd_reg(rd) + rd_reg(rs2));
          end else if (rd == 0) begin
            r.status = ST_BREAK;
            r.next_pc = pc;
          end else begin
            // target comes from the old register value, before the link write
            t = rd_reg(rd) & ~64'd1;
            wr_reg(r, 5'd1, pc + 2);
            r.next_pc = t;
          end
        end
        3'd6: give_store(r, rd_reg(5'd2) + {56'd0, c[8:7], c[12:9], 2'b00}, SZ_W, rd_reg(rs2));
        3'd7: give_store(r, rd_reg(5'd2) + {55'd0, c[9:7], c[12:10], 3'b000}, SZ_D,
                         rd_reg(rs2));
        default: return 0;
      endcase
      return 1;
    endfunction

    // notes one accepted input and predicts its result
    function void note_input(bit cmd, logic [15:0] c, logic [63:0] pc, logic [63:0] ld);
      res_t r;
      bit   ok;
      logic [63:0] v;
      int bits;
      r = '0;
      if (cmd == CMD_RESP) begin
        if (ld_pend) begin
          bits = 8 << ld_width;
          v = (bits == 64) ? ld : (ld & ((64'd1 << bits) - 1));
          if (ld_sign) v = sext(v, bits);
          wr_reg(r, ld_dest, v);
          r.status = ST_LOADED;
          ld_pend = 0;
        end
      end else begin
        r.next_pc = pc + 2;
        case (c[1:0])
          QUAD0: ok = run_q0(r, c);
          QUAD1: ok = run_q1(r, c, pc);
          QUAD2: ok = run_q2(r, c, pc);
          default: ok = 0;
        endcase
        if (!ok) begin
          r = '0;
          r.status = ST_ILLEGAL;
          r.next_pc = pc;
        end
      end
      pending_q.push_back(r);
    endfunction

    // checks one result transfer against the oldest prediction
    function void check_result(res_t got);
      res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer status=%0d", got.status);
        return;
      end
      e = pending_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d pc=%h a=%h sz=%0d sd=%h wb=%0d/%0d/%h",
                   e.status, e.next_pc, e.addr, e.size, e.sdata, e.wbv, e.wbr, e.wbval,
                   "\n          got st=%0d pc=%h a=%h sz=%0d sd=%h wb=%0d/%0d/%h",
                   got.status, got.next_pc, got.addr, got.size, got.sdata, got.wbv,
                   got.wbr, got.wbval);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_cmd;
  logic [15:0] in_instr;
  logic [63:0] in_pc, in_load_data;
  logic        out_valid, out_stall;
  logic [2:0]  out_status;
  logic [63:0] out_next_pc, out_mem_address, out_store_data, out_wb_value;
  logic [1:0]  out_mem_size;
  logic        out_wb_valid;
  logic [4:0]  out_wb_reg;

  compressed_riscv_execute_unit dut (.*);

  rvc_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;       // long receiver hold-off requested
  int  quiet_cycles;   // watchdog: cycles without any transfer
  bit  timed_out;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // one input transfer; the sender may idle before offering it
  task automatic send_item(bit cmd, logic [15:0] c, logic [63:0] pc, logic [63:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_instr <= c;
    in_pc <= pc;
    in_load_data <= ld;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, c, pc, ld);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random instruction biased toward quadrants 0 to 2
  function automatic logic [15:0] rand_instr();
    logic [15:0] c;
    c = 16'($urandom);
    if ($urandom_range(9) != 0) c[1:0] = 2'($urandom_range(2));
    return c;
  endfunction

  // random instructions mixed with load responses, some sent with no load pending
  task automatic random_phase(int n);
    logic [15:0] c;
    for (int i = 0; i < n; i++) begin
      if (sb.ld_pend && $urandom_range(3) == 0)
        send_item(CMD_RESP, 16'($urandom), rand64(), rand64());
      else if ($urandom_range(40) == 0)
        send_item(CMD_RESP, 16'($urandom), rand64(), rand64());
      else begin
        c = rand_instr();
        send_item(CMD_EXEC, c, $urandom_range(7) == 0 ? rand64() : {$urandom, 16'h0, 16'h0},
                  rand64());
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall)
        sb.check_result('{out_status, out_next_pc, out_mem_address, out_mem_size,
                          out_store_data, out_wb_valid, out_wb_reg, out_wb_value});
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] seed_ops [$];
    sb = new();
    rst_n = 0;
    in_valid = 0; in_cmd = 0; in_instr = 0; in_pc = 0; in_load_data = 0;
    hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0; timed_out = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: register setup, a sample of classes, reserved forms, extremes
    seed_ops = '{16'h4581,   // li x11,0 hint-free
                 16'h75fd,   // lui x11 all ones top
                 16'h15fd,   // addi x11,-1
                 16'h0000,   // addi4spn zero: illegal
                 16'h6101,   // addi16sp zero: illegal
                 16'h6581,   // lui zero imm: illegal
                 16'h2001,   // addiw x0: illegal
                 16'h9002,   // ebreak
                 16'h8002,   // jr x0: illegal
                 16'h8582,   // jr x11
                 16'h9582,   // jalr x11
                 16'h05fe,   // slli x11,31
                 16'h0002,   // slli x0 hint
                 16'h9d8d,   // subw
                 16'h9dad,   // addw
                 16'h9dcd,   // mul
                 16'h9df9,   // unary sel 6 reserved
                 16'h9dfd,   // unary sel 7 reserved
                 16'h8d85,   // sub
                 16'hffff,   // quadrant 3
                 16'h2000,   // fld: illegal
                 16'h8d80};  // sh
    foreach (seed_ops[i]) send_item(CMD_EXEC, seed_ops[i], 64'hFFFF_FFFF_FFFF_FFFE, '1);
    send_item(CMD_EXEC, 16'h4188, 64'd0, 64'd0);   // lw -> pending
    send_item(CMD_RESP, 16'h0, '1, 64'h8000_0000);  // sign extends
    send_item(CMD_RESP, 16'h0, 64'd0, '1);          // no pending load
    drain();

    random_phase(400);
    send_idle_pct = 64; random_phase(350);
    send_idle_pct = 0; recv_stall_pct = 64; random_phase(350);
    send_idle_pct = 24; recv_stall_pct = 24; random_phase(300);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      random_phase(100);
    join
    drain();
    random_phase(100);
    drain();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
